// File: hw/rtl/mm4_pkg.sv
// Shared constants and controller/datapath interface types for the 4x4 matrix multiplier.
package mm4_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIM_BITS = 2;
  localparam int SLOT_BITS = 2 * DIM_BITS;
  localparam int SLOT_COUNT = 1 << SLOT_BITS;

  typedef struct packed {
    logic                 load;
    logic [SLOT_BITS-1:0] load_slot;
    logic                 issue;
    logic [SLOT_BITS-1:0] elem;
    logic [DIM_BITS-1:0]  k;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } status_t;

endpackage

// File: hw/rtl/matrix_multiply_4x4.sv
// Operation: sixteen load words are taken at one per cycle while start is held; after the
// sixteenth load, one k term per cycle enters the pipeline through four half-width
// partial-product multipliers, and one product word is given out per element once its four terms are summed.
// The receiver cannot stall results.
// Reset (rst, synchronous) clears the load position and pipeline; stores are not cleared.
module matrix_multiply_4x4 #(
  parameter int VALUE_WIDTH = mm4_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  output logic                          result_valid,
  output logic signed [VALUE_WIDTH-1:0] product_value,
  output logic [mm4_pkg::SLOT_BITS-1:0] product_index,
  output logic                          last_of_run
);

  mm4_pkg::cmd_t    cmd;
  mm4_pkg::status_t status;

  mm4_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  mm4_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .left_value    (left_value),
    .right_value   (right_value),
    .result_valid  (result_valid),
    .product_value (product_value),
    .product_index (product_index),
    .last_of_run   (last_of_run)
  );

endmodule

// File: hw/rtl/mm4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/mm4_ctrl.sv
// Controller state machine: load sequencing, term issue and pipeline drain.
module mm4_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output mm4_pkg::cmd_t    cmd,
  input  mm4_pkg::status_t status
);

  localparam logic [1:0] ST_LOAD    = 2'd0;
  localparam logic [1:0] ST_COMPUTE = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;
  localparam int STEP_BITS = mm4_pkg::SLOT_BITS + mm4_pkg::DIM_BITS;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  logic [mm4_pkg::SLOT_BITS-1:0] load_count;
  logic [mm4_pkg::SLOT_BITS-1:0] load_count_next;
  logic [STEP_BITS-1:0]         step;
  logic [STEP_BITS-1:0]         step_next;

  assign busy = (state != ST_LOAD);

  always_comb begin
    state_next = state;
    load_count_next = load_count;
    step_next = step;
    cmd.load = 1'b0;
    cmd.load_slot = load_count;
    cmd.issue = 1'b0;
    cmd.elem = step[STEP_BITS-1:mm4_pkg::DIM_BITS];
    cmd.k = step[mm4_pkg::DIM_BITS-1:0];
    case (state)
      ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          load_count_next = load_count + 1'b1;
          if (load_count == '1) begin
            state_next = ST_COMPUTE;
            step_next = '0;
          end
        end
      end
      ST_COMPUTE: begin
        // One k term of one product element enters the datapath each cycle.
        cmd.issue = 1'b1;
        step_next = step + 1'b1;
        if (step == '1) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      load_count <= '0;
      step <= '0;
    end else begin
      state <= state_next;
      load_count <= load_count_next;
      step <= step_next;
    end
  end

endmodule

// File: hw/rtl/mm4_datapath.sv
// Datapath: element stores, split multiplier, accumulator and saturating output stage.
module mm4_datapath #(
  parameter int VALUE_WIDTH = mm4_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mm4_pkg::cmd_t                 cmd,
  output mm4_pkg::status_t              status,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  output logic                          result_valid,
  output logic signed [VALUE_WIDTH-1:0] product_value,
  output logic [mm4_pkg::SLOT_BITS-1:0] product_index,
  output logic                          last_of_run
);

  localparam int W = VALUE_WIDTH;
  localparam int H = (W + 1) / 2;
  localparam int HI_W = W - H;
  localparam int OP_W = H + 1;
  localparam int PP_W = 2 * OP_W;
  localparam int ACC_W = 2 * W + 2;
  localparam int TOP_W = ACC_W - mm4_pkg::FRAC_BITS - W + 1;
  localparam int SB = mm4_pkg::SLOT_BITS;
  localparam int DB = mm4_pkg::DIM_BITS;

  logic [W-1:0]  left_rd;
  logic [W-1:0]  right_rd;
  logic [SB-1:0] left_addr;
  logic [SB-1:0] right_addr;

  // Left is read at row*4+k, right at k*4+col.
  assign left_addr  = {cmd.elem[SB-1:DB], cmd.k};
  assign right_addr = {cmd.k, cmd.elem[DB-1:0]};

  mm4_ram #(.WIDTH(W), .DEPTH(mm4_pkg::SLOT_COUNT)) u_left_ram (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (cmd.load_slot),
    .wr_data (left_value),
    .rd_en   (cmd.issue),
    .rd_addr (left_addr),
    .rd_data (left_rd)
  );

  mm4_ram #(.WIDTH(W), .DEPTH(mm4_pkg::SLOT_COUNT)) u_right_ram (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (cmd.load_slot),
    .wr_data (right_value),
    .rd_en   (cmd.issue),
    .rd_addr (right_addr),
    .rd_data (right_rd)
  );

  // Pipeline tags that travel with the data.
  logic          s1v, s2v, s3v, s4v;
  logic          s1_first, s2_first, s3_first;
  logic          s1_last, s2_last, s3_last;
  logic [SB-1:0] s1_elem, s2_elem, s3_elem, s4_elem;

  // Each operand is split into an unsigned low half and a signed high half,
  // so every partial product is a signed multiply of at most OP_W bits.
  logic signed [OP_W-1:0] a_lo, a_hi, b_lo, b_hi;
  assign a_lo = $signed({1'b0, left_rd[H-1:0]});
  assign b_lo = $signed({1'b0, right_rd[H-1:0]});
  assign a_hi = $signed({{(OP_W - HI_W){left_rd[W-1]}}, left_rd[W-1:H]});
  assign b_hi = $signed({{(OP_W - HI_W){right_rd[W-1]}}, right_rd[W-1:H]});

  logic signed [PP_W-1:0]  pp_ll, pp_lh, pp_hl, pp_hh;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc;
  logic [TOP_W-1:0]        acc_top;
  logic                    in_range;

  assign acc_top  = acc[ACC_W-1:mm4_pkg::FRAC_BITS + W - 1];
  assign in_range = (&acc_top) || !(|acc_top);

  assign status.pipe_busy = s1v | s2v | s3v | s4v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1v <= cmd.issue;
      s2v <= s1v;
      s3v <= s2v;
      s4v <= s3v & s3_last;
      result_valid <= s4v;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (cmd.k == '0);
    s1_last  <= (cmd.k == '1);
    s1_elem  <= cmd.elem;

    pp_ll    <= a_lo * b_lo;
    pp_lh    <= a_lo * b_hi;
    pp_hl    <= a_hi * b_lo;
    pp_hh    <= a_hi * b_hi;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_elem  <= s1_elem;

    term     <= ACC_W'(pp_ll)
              + ((ACC_W'(pp_lh) + ACC_W'(pp_hl)) <<< H)
              + (ACC_W'(pp_hh) <<< (2 * H));
    s3_first <= s2_first;
    s3_last  <= s2_last;
    s3_elem  <= s2_elem;

    if (s3v) begin
      acc <= s3_first ? term : acc + term;
    end
    s4_elem <= s3_elem;

    if (s4v) begin
      if (in_range) begin
        product_value <= acc[mm4_pkg::FRAC_BITS + W - 1:mm4_pkg::FRAC_BITS];
      end else if (acc[ACC_W-1]) begin
        product_value <= {1'b1, {(W - 1){1'b0}}};
      end else begin
        product_value <= {1'b0, {(W - 1){1'b1}}};
      end
      product_index <= s4_elem;
      last_of_run   <= (s4_elem == '1);
    end
  end

endmodule

// File: sim/product_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares the product words of the 4x4 matrix multiplier.
module product_checker #(
  parameter int VALUE_WIDTH = mm4_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  input  logic                          result_valid,
  input  logic signed [VALUE_WIDTH-1:0] product_value,
  input  logic [mm4_pkg::SLOT_BITS-1:0] product_index,
  input  logic                          last_of_run,
  output int                            fail_count,
  output int                            outstanding
);

  // Four products of two signed words plus carry room for their sum.
  localparam int ACC_W = 2 * VALUE_WIDTH + 4;
  localparam int DIM = 1 << mm4_pkg::DIM_BITS;
  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [mm4_pkg::SLOT_BITS-1:0] pos;
    logic                          is_last;
  } product_t;

  logic signed [VALUE_WIDTH-1:0] left_elems [mm4_pkg::SLOT_COUNT];
  logic signed [VALUE_WIDTH-1:0] right_elems [mm4_pkg::SLOT_COUNT];
  logic [mm4_pkg::SLOT_BITS-1:0] load_slot;
  product_t product_q [$];

  function automatic logic signed [VALUE_WIDTH-1:0] saturated_dot(int row, int col);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      a = left_elems[row*DIM + k];
      b = right_elems[k*DIM + col];
      acc = acc + a * b;
    end
    // Arithmetic shift floors toward minus infinity, then clamp to the word range.
    acc = acc >>> mm4_pkg::FRAC_BITS;
    if (acc > SAT_MAX) return SAT_MAX[VALUE_WIDTH-1:0];
    if (acc < SAT_MIN) return SAT_MIN[VALUE_WIDTH-1:0];
    return acc[VALUE_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin : track
    product_t entry;
    product_t want;
    if (rst) begin
      load_slot = '0;
      product_q.delete();
    end else begin
      if (start && !busy) begin
        left_elems[load_slot] = left_value;
        right_elems[load_slot] = right_value;
        if (load_slot == mm4_pkg::SLOT_COUNT - 1) begin
          for (int pos = 0; pos < mm4_pkg::SLOT_COUNT; pos++) begin
            entry.value = saturated_dot(pos / DIM, pos % DIM);
            entry.pos = mm4_pkg::SLOT_BITS'(pos);
            entry.is_last = (pos == mm4_pkg::SLOT_COUNT - 1);
            product_q.push_back(entry);
          end
        end
        load_slot = load_slot + 1'b1;
      end
      if (result_valid) begin
        if (product_q.size() == 0) begin
          $error("unexpected product word: value %0d index %0d", product_value, product_index);
          fail_count++;
        end else begin
          want = product_q.pop_front();
          if (product_value !== want.value) begin
            $error("product_value: expected %0d, got %0d", want.value, product_value);
            fail_count++;
          end
          if (product_index !== want.pos) begin
            $error("product_index: expected %0d, got %0d", want.pos, product_index);
            fail_count++;
          end
          if (last_of_run !== want.is_last) begin
            $error("last_of_run: expected %0b, got %0b", want.is_last, last_of_run);
            fail_count++;
          end
        end
      end
    end
    outstanding = product_q.size();
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench that loads matrix pairs into the 4x4 multiplier and reports the verdict.
module testbench;

  localparam int VALUE_WIDTH = mm4_pkg::VALUE_WIDTH_DEFAULT;
  localparam int DIM = 1 << mm4_pkg::DIM_BITS;
  localparam int RANDOM_SETS = 28;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic signed [VALUE_WIDTH-1:0] WORD_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] WORD_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] WORD_ONE =
    VALUE_WIDTH'(1) << mm4_pkg::FRAC_BITS;

  typedef enum int {FILL_FULL, FILL_SMALL, FILL_BORDER, FILL_SPECIAL} fill_e;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic signed [VALUE_WIDTH-1:0] left_value;
  logic signed [VALUE_WIDTH-1:0] right_value;
  logic                          result_valid;
  logic signed [VALUE_WIDTH-1:0] product_value;
  logic [mm4_pkg::SLOT_BITS-1:0] product_index;
  logic                          last_of_run;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit burst = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  matrix_multiply_4x4 #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .left_value   (left_value),
    .right_value  (right_value),
    .result_valid (result_valid),
    .product_value(product_value),
    .product_index(product_index),
    .last_of_run  (last_of_run)
  );

  product_checker #(.VALUE_WIDTH(VALUE_WIDTH)) product_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .left_value   (left_value),
    .right_value  (right_value),
    .result_valid (result_valid),
    .product_value(product_value),
    .product_index(product_index),
    .last_of_run  (last_of_run),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // A stretch with no accepted word and no product word means the block has hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [VALUE_WIDTH-1:0] draw_elem(fill_e fill);
    logic signed [VALUE_WIDTH-1:0] v;
    case (fill)
      FILL_FULL: begin
        v = VALUE_WIDTH'($urandom);
      end
      FILL_SMALL: begin
        v = VALUE_WIDTH'($urandom_range(0, 1 << 21)) - VALUE_WIDTH'(1 << 20);
      end
      FILL_BORDER: begin
        // Magnitudes here put the dot product close to the saturation bound.
        v = VALUE_WIDTH'($urandom_range(1 << 22, (1 << 24) - 1));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = 1;
          2: v = -1;
          3: v = WORD_ONE;
          4: v = -WORD_ONE;
          5: v = WORD_MAX;
          6: v = WORD_MIN;
          default: v = WORD_ONE >>> 1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that follows
  // the accepting rising edge. Busy is stable here, so it is what the next edge sees.
  task automatic send_word(input logic signed [VALUE_WIDTH-1:0] lv,
                           input logic signed [VALUE_WIDTH-1:0] rv);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    left_value <= lv;
    right_value <= rv;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic signed [VALUE_WIDTH-1:0] row_vals [DIM];
    logic signed [VALUE_WIDTH-1:0] col_vals [DIM];
    fill_e left_fill;
    fill_e right_fill;
    rst = 1'b1;
    start = 1'b0;
    left_value = '0;
    right_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // One directed pair: rows of extremes against columns of extremes, so that the
    // product holds both saturation limits, floor rounding of negatives and exact words.
    row_vals = '{WORD_MIN, WORD_MAX, -1, WORD_ONE};
    col_vals = '{WORD_MIN, WORD_MAX, 1, 0};
    for (int pos = 0; pos < mm4_pkg::SLOT_COUNT; pos++) begin
      send_word(row_vals[pos / DIM], col_vals[pos % DIM]);
    end

    for (int set = 0; set < RANDOM_SETS; set++) begin
      burst = ($urandom_range(0, 3) == 0);
      left_fill = fill_e'($urandom_range(0, 3));
      right_fill = fill_e'($urandom_range(0, 3));
      for (int pos = 0; pos < mm4_pkg::SLOT_COUNT; pos++) begin
        send_word(draw_elem(left_fill), draw_elem(right_fill));
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
